// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the shelf rectangle packer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants shared by the shelf rectangle packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

	localparam int DIM_BITS_DEF     = 16;
	localparam int MAX_QUANTITY_DEF = 64;
	localparam int QTY_BITS         = 7;
	localparam int CFG_IDX_BITS     = 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SHEET_WIDTH  = 1'b0,
		CFG_SHEET_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIT,
		ST_ROW,
		ST_SHEET
	} state_t;

	typedef struct packed {
		logic load;
		logic place;
		logic swap;
		logic over;
		logic last;
		logic open_row;
		logic open_sheet;
	} cmd_t;

	typedef struct packed {
		logic fit_a;
		logic fit_b;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/srp_in_if.sv
// ----------------------------------------------------------------------------
// srp_in_if
// Piece-kind channel: width, height and quantity with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface srp_in_if #(
	parameter int DIM_BITS = srp_pkg::DIM_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic [DIM_BITS-1:0]          piece_width;
	logic [DIM_BITS-1:0]          piece_height;
	logic [srp_pkg::QTY_BITS-1:0] quantity;

	modport source (output valid, output piece_width, output piece_height,
		output quantity, input ready);
	modport sink (input valid, input piece_width, input piece_height,
		input quantity, output ready);
endinterface

`default_nettype wire

// File: rtl/srp_out_if.sv
// ----------------------------------------------------------------------------
// srp_out_if
// Placement channel: one beat per placed copy with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface srp_out_if #(
	parameter int DIM_BITS = srp_pkg::DIM_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] sheet_index;
	logic [DIM_BITS:0]   pos_x;
	logic [DIM_BITS:0]   pos_y;
	logic [DIM_BITS-1:0] placed_width;
	logic [DIM_BITS-1:0] placed_height;
	logic                rotated;
	logic                overflow;
	logic                last;

	modport source (output valid, output sheet_index, output pos_x, output pos_y,
		output placed_width, output placed_height, output rotated,
		output overflow, output last, input ready);
	modport sink (input valid, input sheet_index, input pos_x, input pos_y,
		input placed_width, input placed_height, input rotated,
		input overflow, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/srp_ctrl.sv
// ----------------------------------------------------------------------------
// srp_ctrl
// Sequencer that walks each copy through the fit, new-row and new-sheet steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srp_ctrl #(
	parameter int MAX_QUANTITY = srp_pkg::MAX_QUANTITY_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [srp_pkg::QTY_BITS-1:0] quantity,
	output logic                              in_ready,
	input  wire srp_pkg::status_t             status,
	output srp_pkg::cmd_t                     cmd
);

	localparam int QtyBits = srp_pkg::QTY_BITS;
	localparam logic [QtyBits-1:0] MaxQty = QtyBits'(MAX_QUANTITY);

	srp_pkg::state_t    state_q, state_d;
	logic [QtyBits-1:0] cnt_q;
	logic [QtyBits-1:0] qty_clamped;

	assign qty_clamped = (quantity > MaxQty) ? MaxQty : quantity;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			srp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			srp_pkg::ST_FIT: begin
				if (status.fit_a || status.fit_b) begin
					cmd.place = status.out_free;
					cmd.swap = !status.fit_a;
				end else begin
					cmd.open_row = 1'b1;
				end
			end
			srp_pkg::ST_ROW: begin
				if (status.fit_a) begin
					cmd.place = status.out_free;
				end else begin
					cmd.open_sheet = 1'b1;
				end
			end
			srp_pkg::ST_SHEET: begin
				cmd.place = status.out_free;
				cmd.swap = !status.fit_a;
				cmd.over = !status.fit_a && !status.fit_b;
			end
			default: begin
				cmd = '0;
			end
		endcase
		cmd.last = (cnt_q == QtyBits'(1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			srp_pkg::ST_IDLE: begin
				if (in_valid && qty_clamped != '0) begin
					state_d = srp_pkg::ST_FIT;
				end
			end
			srp_pkg::ST_FIT, srp_pkg::ST_ROW, srp_pkg::ST_SHEET: begin
				if (cmd.place) begin
					state_d = cmd.last ? srp_pkg::ST_IDLE : srp_pkg::ST_FIT;
				end else if (cmd.open_row) begin
					state_d = srp_pkg::ST_ROW;
				end else if (cmd.open_sheet) begin
					state_d = srp_pkg::ST_SHEET;
				end
			end
			default: begin
				state_d = srp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srp_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= qty_clamped;
			end else if (cmd.place) begin
				cnt_q <= cnt_q - QtyBits'(1);
			end
		end
	end

	`SRP_ASSERT_IMP(a_busy_has_copies, clk, arst_n, state_q != srp_pkg::ST_IDLE, cnt_q != '0)
	`SRP_ASSERT_NXT(a_sheet_places, clk, arst_n, state_q == srp_pkg::ST_SHEET && status.out_free, state_q == srp_pkg::ST_IDLE || state_q == srp_pkg::ST_FIT)
	`SRP_ASSERT_IMP(a_row_after_fit, clk, arst_n, cmd.open_row, state_q == srp_pkg::ST_FIT)

endmodule

`default_nettype wire

// File: rtl/srp_datapath.sv
// ----------------------------------------------------------------------------
// srp_datapath
// Cursor, row and sheet registers, fit tests and the placement output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srp_datapath #(
	parameter int DIM_BITS = srp_pkg::DIM_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [DIM_BITS-1:0]              cfg_wdata,
	input  wire logic [DIM_BITS-1:0]              piece_width,
	input  wire logic [DIM_BITS-1:0]              piece_height,
	input  wire srp_pkg::cmd_t                    cmd,
	output srp_pkg::status_t                      status,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic [DIM_BITS-1:0]                   sheet_index,
	output logic [DIM_BITS:0]                     pos_x,
	output logic [DIM_BITS:0]                     pos_y,
	output logic [DIM_BITS-1:0]                   placed_width,
	output logic [DIM_BITS-1:0]                   placed_height,
	output logic                                  rotated,
	output logic                                  overflow,
	output logic                                  last
);

	localparam int Cw = DIM_BITS + 1;
	localparam int Sw = DIM_BITS + 2;

	logic [DIM_BITS-1:0] sheet_w_q, sheet_h_q;
	logic [DIM_BITS-1:0] piece_w_q, piece_h_q;
	logic [Cw-1:0]       cursor_x_q, cursor_y_q;
	logic [DIM_BITS-1:0] row_h_q;
	logic [DIM_BITS-1:0] sheet_cnt_q;
	logic                out_valid_q;

	logic [Sw-1:0]       sum_xw, sum_xh, sum_yw, sum_yh, sum_row, sum_x_pl;
	logic [Sw-1:0]       lim_w, lim_h;
	logic [DIM_BITS-1:0] w_pl, h_pl;
	logic                out_free;

	assign sum_xw  = Sw'(cursor_x_q) + Sw'(piece_w_q);
	assign sum_xh  = Sw'(cursor_x_q) + Sw'(piece_h_q);
	assign sum_yw  = Sw'(cursor_y_q) + Sw'(piece_w_q);
	assign sum_yh  = Sw'(cursor_y_q) + Sw'(piece_h_q);
	assign sum_row = Sw'(cursor_y_q) + Sw'(row_h_q);
	assign lim_w   = Sw'(sheet_w_q);
	assign lim_h   = Sw'(sheet_h_q);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		status.fit_a = (sum_xw <= lim_w) && (sum_yh <= lim_h);
		status.fit_b = (sum_xh <= lim_w) && (sum_yw <= lim_h);
		status.out_free = out_free;
	end

	assign w_pl     = cmd.swap ? piece_h_q : piece_w_q;
	assign h_pl     = cmd.swap ? piece_w_q : piece_h_q;
	assign sum_x_pl = cmd.swap ? sum_xh : sum_xw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sheet_w_q <= '1;
			sheet_h_q <= '1;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			row_h_q <= '0;
			sheet_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					srp_pkg::CFG_SHEET_WIDTH: sheet_w_q <= cfg_wdata;
					srp_pkg::CFG_SHEET_HEIGHT: sheet_h_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (cmd.place) begin
				cursor_x_q <= sum_x_pl[Sw-1] ? '1 : sum_x_pl[Cw-1:0];
				if (h_pl > row_h_q) begin
					row_h_q <= h_pl;
				end
			end else if (cmd.open_row) begin
				cursor_x_q <= '0;
				cursor_y_q <= sum_row[Sw-1] ? '1 : sum_row[Cw-1:0];
				row_h_q <= '0;
			end else if (cmd.open_sheet) begin
				cursor_x_q <= '0;
				cursor_y_q <= '0;
				row_h_q <= '0;
				if (sheet_cnt_q != '1) begin
					sheet_cnt_q <= sheet_cnt_q + DIM_BITS'(1);
				end
			end
			if (cmd.place) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			piece_w_q <= piece_width;
			piece_h_q <= piece_height;
		end
		if (cmd.place) begin
			sheet_index <= sheet_cnt_q;
			pos_x <= cursor_x_q;
			pos_y <= cursor_y_q;
			placed_width <= w_pl;
			placed_height <= h_pl;
			rotated <= cmd.swap;
			overflow <= cmd.over;
			last <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;

	`SRP_ASSERT_IMP(a_place_has_room, clk, arst_n, cmd.place, out_free)
	`SRP_ASSERT_NXT(a_place_shows_beat, clk, arst_n, cmd.place, out_valid_q)
	`SRP_ASSERT_NXT(a_sheet_resets_row, clk, arst_n, cmd.open_sheet, cursor_x_q == '0 && cursor_y_q == '0 && row_h_q == '0)

endmodule

`default_nettype wire

// File: rtl/shelf_rectangle_packer.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_packer
// Next-fit shelf packer that places copies of piece kinds onto sheets.
// ----------------------------------------------------------------------------
// The pieces channel takes one piece kind per beat (width, height, quantity).
// Each copy leaves as one beat on the placements channel with its sheet,
// corner, placed size and the rotated, overflow and last flags. A quantity
// of zero gives no beat; quantities above MAX_QUANTITY are clamped.
// A copy that fits at the cursor, turned or not, is placed there. Otherwise the
// sequencer opens a new row, where only the unturned copy is tried, and then a
// new sheet, where the copy is placed turned or not, flagged overflow if it
// still does not fit. The pieces channel stays not ready until the last copy
// of an item has been placed. A single output register holds the current beat;
// while the receiver stalls, the sequencer waits on the next copy. The next
// piece kind is accepted as soon as the last copy sits in the output register.
// Sheet size is written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it.
// Reset sets both sheet dimensions to all ones, clears the cursors, row height
// and sheet count, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_rectangle_packer #(
	parameter int DIM_BITS     = srp_pkg::DIM_BITS_DEF,
	parameter int MAX_QUANTITY = srp_pkg::MAX_QUANTITY_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [DIM_BITS-1:0]              cfg_wdata,
	srp_in_if.sink                                pieces,
	srp_out_if.source                             placements
);

	srp_pkg::cmd_t    cmd;
	srp_pkg::status_t status;
	logic             in_ready;

	srp_ctrl #(
		.MAX_QUANTITY(MAX_QUANTITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pieces.valid),
		.quantity (pieces.quantity),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	srp_datapath #(
		.DIM_BITS(DIM_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.piece_width   (pieces.piece_width),
		.piece_height  (pieces.piece_height),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (placements.ready),
		.out_valid     (placements.valid),
		.sheet_index   (placements.sheet_index),
		.pos_x         (placements.pos_x),
		.pos_y         (placements.pos_y),
		.placed_width  (placements.placed_width),
		.placed_height (placements.placed_height),
		.rotated       (placements.rotated),
		.overflow      (placements.overflow),
		.last          (placements.last)
	);

	assign pieces.ready = in_ready;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shelf rectangle packer.
// ----------------------------------------------------------------------------
// Piece kinds go in on the pieces channel. Every placement beat that comes out
// is compared field by field with the oldest entry of a queue. A packing model
// in the bench keeps its own cursors, row height, sheet count and sheet size
// and fills that queue.
// The run has three parts. A table of directed rows comes first: extremes,
// turned pieces, overflow, quantity zero and above the maximum, and zero
// sizes. Random phases follow, each with its own sheet size. A last phase
// uses a zero sheet width, so that every copy opens a sheet and overflows.
// Both sides idle at random outside phase 4 and the last phase. In one phase
// the receiver holds off for a long stretch, so that the packer stalls its input.
// ----------------------------------------------------------------------------

module tb;

	localparam int DW             = srp_pkg::DIM_BITS_DEF;
	localparam int MAX_Q          = srp_pkg::MAX_QUANTITY_DEF;
	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 55;
	localparam int SAT_ITEMS      = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [DW:0] CUR_MAX = '1;

	localparam srp_pkg::cfg_reg_t REG_W = srp_pkg::CFG_SHEET_WIDTH;
	localparam srp_pkg::cfg_reg_t REG_H = srp_pkg::CFG_SHEET_HEIGHT;

	typedef struct packed {
		logic [DW-1:0] sheet;
		logic [DW:0]   pos_x;
		logic [DW:0]   pos_y;
		logic [DW-1:0] width;
		logic [DW-1:0] height;
		logic          rot;
		logic          over;
		logic          last;
	} placement_t;

	typedef enum bit {ROW_CONFIG, ROW_PIECE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		srp_pkg::cfg_reg_t reg_sel;
		logic [DW-1:0]     wdata;
		logic [DW-1:0]     pw;
		logic [DW-1:0]     ph;
		logic [6:0]        qty;
		bit                typed;
		placement_t        exp;
	} stim_row_t;

	localparam placement_t NO_EXP = '0;
	localparam int N_DIR = 24;

	stim_row_t dir_rows [N_DIR] = '{
		'{ROW_PIECE,  REG_W, 16'd0,     16'd1,     16'd1,     7'd1,   1'b1,
			'{16'd0, 17'd0, 17'd0, 16'd1, 16'd1, 1'b0, 1'b0, 1'b1}},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd65535, 16'd65535, 7'd1,   1'b1,
			'{16'd1, 17'd0, 17'd0, 16'd65535, 16'd65535, 1'b0, 1'b0, 1'b1}},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd7,     16'd9,     7'd0,   1'b0, NO_EXP},
		'{ROW_CONFIG, REG_W, 16'd10,    16'd0,     16'd0,     7'd0,   1'b0, NO_EXP},
		'{ROW_CONFIG, REG_H, 16'd10,    16'd0,     16'd0,     7'd0,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd20,    16'd5,     7'd1,   1'b1,
			'{16'd2, 17'd0, 17'd0, 16'd5, 16'd20, 1'b1, 1'b1, 1'b1}},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd3,     16'd4,     7'd1,   1'b1,
			'{16'd2, 17'd5, 17'd0, 16'd3, 16'd4, 1'b0, 1'b0, 1'b1}},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd4,     16'd2,     7'd1,   1'b1,
			'{16'd2, 17'd8, 17'd0, 16'd2, 16'd4, 1'b1, 1'b0, 1'b1}},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd2,     16'd3,     7'd127, 1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd10,    16'd10,    7'd64,  1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd0,     16'd0,     7'd3,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd11,    16'd1,     7'd2,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'h5555,  16'hAAAA,  7'd85,  1'b0, NO_EXP},
		'{ROW_CONFIG, REG_W, 16'd0,     16'd0,     16'd0,     7'd0,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd1,     16'd1,     7'd2,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd0,     16'd5,     7'd1,   1'b0, NO_EXP},
		'{ROW_CONFIG, REG_W, 16'd65535, 16'd0,     16'd0,     7'd0,   1'b0, NO_EXP},
		'{ROW_CONFIG, REG_H, 16'd1,     16'd0,     16'd0,     7'd0,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd65535, 16'd1,     7'd4,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd1,     16'd65535, 7'd3,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'hAAAA,  16'h5555,  7'd42,  1'b0, NO_EXP},
		'{ROW_CONFIG, REG_H, 16'd65535, 16'd0,     16'd0,     7'd0,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd32768, 16'd32768, 7'd5,   1'b0, NO_EXP},
		'{ROW_PIECE,  REG_W, 16'd0,     16'd65535, 16'd0,     7'd2,   1'b0, NO_EXP}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	srp_pkg::cfg_reg_t cfg_index;
	logic [DW-1:0]     cfg_wdata;

	srp_in_if  #(.DIM_BITS(DW)) pieces_if ();
	srp_out_if #(.DIM_BITS(DW)) place_if ();

	shelf_rectangle_packer #(
		.DIM_BITS     (DW),
		.MAX_QUANTITY (MAX_Q)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pieces     (pieces_if),
		.placements (place_if)
	);

	// Packing model state.
	logic [DW-1:0] sheet_w = '1;
	logic [DW-1:0] sheet_h = '1;
	logic [DW:0]   cur_x   = '0;
	logic [DW:0]   cur_y   = '0;
	logic [DW-1:0] row_h   = '0;
	logic [DW-1:0] sheet_no = '0;

	placement_t placement_q [$];

	int  errors       = 0;
	int  items_sent   = 0;
	int  beats_seen   = 0;
	int  rot_seen     = 0;
	int  over_seen    = 0;
	int  settings     = 0;
	int  quiet_cycles = 0;
	bit  idle_on      = 1'b1;
	bit  hold_req     = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit fits_at(logic [DW-1:0] w, logic [DW-1:0] h);
		return (longint'(cur_x) + w <= sheet_w) && (longint'(cur_y) + h <= sheet_h);
	endfunction

	function automatic logic [DW:0] clamp_cursor(longint v);
		return (v > CUR_MAX) ? CUR_MAX : v[DW:0];
	endfunction

	function automatic int pack_item(logic [DW-1:0] pw, logic [DW-1:0] ph, logic [6:0] qty);
		int            n;
		logic [DW-1:0] w;
		logic [DW-1:0] h;
		logic [DW-1:0] t;
		bit            rot;
		placement_t    p;
		n = (qty > MAX_Q) ? MAX_Q : int'(qty);
		for (int k = 0; k < n; k++) begin
			w = pw;
			h = ph;
			rot = 1'b0;
			if (!fits_at(w, h) && fits_at(h, w)) begin
				t = w; w = h; h = t;
				rot = 1'b1;
			end
			if (!fits_at(w, h)) begin
				cur_x = '0;
				cur_y = clamp_cursor(longint'(cur_y) + row_h);
				row_h = '0;
			end
			if (!fits_at(w, h)) begin
				if (sheet_no != '1)
					sheet_no++;
				cur_x = '0;
				cur_y = '0;
				row_h = '0;
			end
			if (!fits_at(w, h)) begin
				t = w; w = h; h = t;
				rot = !rot;
			end
			p.sheet  = sheet_no;
			p.pos_x  = cur_x;
			p.pos_y  = cur_y;
			p.width  = w;
			p.height = h;
			p.rot    = rot;
			p.over   = !fits_at(w, h);
			p.last   = (k == n - 1);
			placement_q = {placement_q, p};
			cur_x = clamp_cursor(longint'(cur_x) + w);
			if (h > row_h)
				row_h = h;
		end
		return n;
	endfunction

	function automatic logic [DW-1:0] draw_dim(logic [DW-1:0] lim);
		case ($urandom_range(0, 9))
			0: return DW'($urandom_range(0, 16'hFFFF));
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return DW'($urandom_range(1, (lim > 3) ? lim / 2 : lim + 1));
		endcase
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic write_reg(input srp_pkg::cfg_reg_t sel, input logic [DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == REG_W)
			sheet_w = value;
		else
			sheet_h = value;
	endtask

	task automatic send_piece(input logic [DW-1:0] pw, input logic [DW-1:0] ph,
		input logic [6:0] qty, input bit typed, input placement_t typed_exp);
		int gap;
		int n;
		n = pack_item(pw, ph, qty);
		if (typed && n == 1)
			placement_q[placement_q.size() - 1] = typed_exp;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			pieces_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pieces_if.valid        <= 1'b1;
		pieces_if.piece_width  <= pw;
		pieces_if.piece_height <= ph;
		pieces_if.quantity     <= qty;
		do @(posedge clk); while (!pieces_if.ready);
		items_sent++;
	endtask

	task automatic finish_phase();
		pieces_if.valid <= 1'b0;
		while (placement_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int stall;
		place_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = idle_on ? $urandom_range(0, 13) : 0;
			end
			if (stall > 0) begin
				place_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			place_if.ready <= 1'b1;
			do @(posedge clk); while (place_if.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		placement_t got;
		placement_t want;
		if (arst_n && place_if.valid && place_if.ready) begin
			got = '{place_if.sheet_index, place_if.pos_x, place_if.pos_y,
				place_if.placed_width, place_if.placed_height, place_if.rotated,
				place_if.overflow, place_if.last};
			beats_seen++;
			rot_seen += got.rot;
			over_seen += got.over;
			if (placement_q.size() == 0) begin
				report("placement beat with nothing pending, sheet", got.sheet, -1);
			end else begin
				want = placement_q.pop_front();
				if (got.sheet !== want.sheet)
					report("sheet_index", got.sheet, want.sheet);
				if (got.pos_x !== want.pos_x)
					report("pos_x", got.pos_x, want.pos_x);
				if (got.pos_y !== want.pos_y)
					report("pos_y", got.pos_y, want.pos_y);
				if (got.width !== want.width)
					report("placed_width", got.width, want.width);
				if (got.height !== want.height)
					report("placed_height", got.height, want.height);
				if (got.rot !== want.rot)
					report("rotated", got.rot, want.rot);
				if (got.over !== want.over)
					report("overflow", got.over, want.over);
				if (got.last !== want.last)
					report("last", got.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pieces_if.valid && pieces_if.ready) || (place_if.valid && place_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no beat for %0d cycles, %0d placements pending",
				$time, quiet_cycles, placement_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [DW-1:0] w_lim;
		logic [DW-1:0] h_lim;
		logic [6:0]    qty;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_W;
		cfg_wdata              <= '0;
		pieces_if.valid        <= 1'b0;
		pieces_if.piece_width  <= '0;
		pieces_if.piece_height <= '0;
		pieces_if.quantity     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CONFIG) begin
				finish_phase();
				write_reg(dir_rows[i].reg_sel, dir_rows[i].wdata);
				settings++;
			end else begin
				send_piece(dir_rows[i].pw, dir_rows[i].ph, dir_rows[i].qty,
					dir_rows[i].typed, dir_rows[i].exp);
			end
		end
		finish_phase();

		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: begin w_lim = '1; h_lim = '1; end
				1: begin w_lim = 16'd1; h_lim = 16'd1; end
				2: begin
					w_lim = DW'($urandom_range(16, 400));
					h_lim = DW'($urandom_range(16, 400));
				end
				3: begin w_lim = '1; h_lim = 16'd1; end
				4: begin w_lim = 16'd1; h_lim = '1; end
				5: begin
					w_lim = DW'($urandom_range(0, 16'hFFFF));
					h_lim = DW'($urandom_range(0, 16'hFFFF));
				end
				6: begin w_lim = '0; h_lim = DW'($urandom_range(1, 500)); end
				default: begin
					w_lim = DW'($urandom_range(100, 3000));
					h_lim = DW'($urandom_range(100, 3000));
				end
			endcase
			write_reg(REG_W, w_lim);
			write_reg(REG_H, h_lim);
			settings++;
			idle_on = (phase != 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 2 && i == 10)
					hold_req = 1'b1;
				qty = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(13, 127))
					: 7'($urandom_range(0, 10));
				send_piece(draw_dim(w_lim), draw_dim(h_lim), qty, 1'b0, NO_EXP);
			end
			finish_phase();
		end

		// With a zero sheet width every copy here opens a sheet and overflows.
		idle_on = 1'b0;
		write_reg(REG_W, '0);
		write_reg(REG_H, DW'($urandom_range(0, 16'hFFFF)));
		settings++;
		for (int i = 0; i < SAT_ITEMS; i++)
			send_piece(DW'($urandom_range(1, 16'hFFFF)), DW'($urandom_range(1, 16'hFFFF)),
				7'(MAX_Q), 1'b0, NO_EXP);
		finish_phase();

		$display("Covered %0d piece kinds over %0d sheet settings, %0d placements checked.",
			items_sent, settings, beats_seen);
		$display("Placements turned: %0d, overflowing: %0d, final sheet index: %0d.",
			rot_seen, over_seen, sheet_no);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
